// ----- src/rrsp_pkg.sv -----
// Shared constants and types for the rotated RGB444 scanline packer.
package rrsp_pkg;

  // Panel geometry in pixels, as the framebuffer is read in rotated order.
  localparam int unsigned Width  = 224;
  localparam int unsigned Height = 240;

  // Counter and address widths.
  localparam int unsigned ColW  = 10;
  localparam int unsigned LineW = 10;
  localparam int unsigned AddrW = 20;

  // Stream payload widths.
  localparam int unsigned PixW   = 16;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned OutDataW = 32;
  localparam int unsigned OutUserW = 2;

  // Result queue depth: one pending byte plus the two bytes of an odd pixel.
  localparam int unsigned QDepth = 3;
  localparam int unsigned QCntW  = 2;

  // One queued result byte with its side information.
  typedef struct packed {
    logic [AddrW-1:0] next_read_address;
    logic             frame_end;
    logic             line_end;
    logic             last_of_item;
    logic [ByteW-1:0] out_byte;
  } res_t;

endpackage

// ----- src/rotated_rgb444_scanline_packer.sv -----
// Top level of the rotated RGB565 to RGB444 scanline packer.
//
//  Channel  Dir  tdata (low bit up)                    tuser / tlast
//  s_axis   in   pixel_color[15:0]                     -
//  m_axis   out  out_byte[7:0], next_read_address      tuser: last_of_item, frame_end;
//                [27:8], zero [31:28]                   tlast: line_end
//
// An accepted pixel writes its bytes into a three-entry result queue at
// the same clock edge, so an even pixel adds one byte and an odd one two.
// The output port moves one byte per cycle while m_axis_tready_i is high,
// and every two pixels make three bytes for it to send.
// Reset clears the counters, the held blue nibble and the queue.
// The input is stalled only when the queue lacks room for this pixel's bytes.
module rotated_rgb444_scanline_packer (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  input  logic [rrsp_pkg::PixW-1:0]          s_axis_tdata_i,   // pixel_color[15:0]
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  output logic [rrsp_pkg::OutDataW-1:0]      m_axis_tdata_o,   // out_byte, next_read_address
  output logic [rrsp_pkg::OutUserW-1:0]      m_axis_tuser_o,   // last_of_item, frame_end
  output logic                               m_axis_tlast_o    // line_end
);

  // Scan state.
  logic [rrsp_pkg::ColW-1:0]  col_q, col_d;
  logic [rrsp_pkg::LineW-1:0] line_q, line_d;
  logic                       phase_q, phase_d;
  logic [3:0]                 blue_q, blue_d;

  // Result queue, head at entry zero.
  rrsp_pkg::res_t             ent_q [rrsp_pkg::QDepth];
  rrsp_pkg::res_t             ent_d [rrsp_pkg::QDepth];
  logic [rrsp_pkg::QCntW-1:0] cnt_q, cnt_d, cnt_mid;

  logic                       push, pop;
  logic [rrsp_pkg::QCntW-1:0] n_new;

  // Colour reduction and address terms.
  logic [3:0]                 red4, green4, blue4;
  logic                       at_line_end, at_frame_end;
  logic [rrsp_pkg::ColW-1:0]  col_rev;
  logic [rrsp_pkg::LineW-1:0] line_rev;
  logic [rrsp_pkg::AddrW-1:0] addr;
  rrsp_pkg::res_t             res0, res1;

  // Handshakes: an odd pixel needs room for two bytes, an even one for one.
  assign n_new           = phase_q ? rrsp_pkg::QCntW'(2) : rrsp_pkg::QCntW'(1);
  assign s_axis_tready_o = ({1'b0, cnt_q} + {1'b0, n_new}) <=
                           (rrsp_pkg::QCntW + 1)'(rrsp_pkg::QDepth);
  assign m_axis_tvalid_o = cnt_q != '0;
  assign push            = s_axis_tvalid_i & s_axis_tready_o;
  assign pop             = m_axis_tvalid_o & m_axis_tready_i;

  // Keep the top four bits of each colour.
  assign red4   = s_axis_tdata_i[15:12];
  assign green4 = s_axis_tdata_i[10:7];
  assign blue4  = s_axis_tdata_i[4:1];

  assign at_line_end  = col_q >= rrsp_pkg::ColW'(rrsp_pkg::Width - 1);
  assign at_frame_end = at_line_end && (line_q >= rrsp_pkg::LineW'(rrsp_pkg::Height - 1));

  // Counter update for the pixel being accepted.
  always_comb begin
    col_d   = col_q;
    line_d  = line_q;
    phase_d = phase_q;
    blue_d  = blue_q;
    if (push) begin
      if (at_line_end) begin
        col_d   = '0;
        phase_d = 1'b0;
        line_d  = at_frame_end ? '0 : line_q + 1'b1;
      end else begin
        col_d   = col_q + 1'b1;
        phase_d = ~phase_q;
      end
      // An even pixel holds its blue nibble unless it closes the line.
      if (!phase_q && !at_line_end) begin
        blue_d = blue4;
      end else begin
        blue_d = '0;
      end
    end
  end

  // Read address of the pixel expected next, from the updated counters.
  assign col_rev  = rrsp_pkg::ColW'(rrsp_pkg::Width - 1) - col_d;
  assign line_rev = rrsp_pkg::LineW'(rrsp_pkg::Height - 1) - line_d;
  assign addr     = rrsp_pkg::AddrW'(col_rev) * rrsp_pkg::AddrW'(rrsp_pkg::Height)
                  + rrsp_pkg::AddrW'(line_rev);

  // Bytes this pixel produces.
  always_comb begin
    res0 = '0;
    res1 = '0;
    res0.next_read_address = addr;
    res1.next_read_address = addr;
    if (!phase_q) begin
      res0.out_byte     = {red4, green4};
      res0.last_of_item = 1'b1;
      res0.line_end     = at_line_end;
      res0.frame_end    = at_frame_end;
    end else begin
      res0.out_byte     = {blue_q, red4};
      res1.out_byte     = {green4, blue4};
      res1.last_of_item = 1'b1;
      res1.line_end     = at_line_end;
      res1.frame_end    = at_frame_end;
    end
  end

  // Queue update: pop the head, then append the new bytes behind what remains.
  always_comb begin
    cnt_mid = cnt_q - rrsp_pkg::QCntW'(pop);
    for (int i = 0; i < rrsp_pkg::QDepth; i++) begin
      ent_d[i] = ent_q[i];
    end
    if (pop) begin
      for (int i = 0; i < rrsp_pkg::QDepth - 1; i++) begin
        ent_d[i] = ent_q[i+1];
      end
    end
    for (int i = 0; i < rrsp_pkg::QDepth; i++) begin
      if (push && (rrsp_pkg::QCntW'(i) == cnt_mid)) begin
        ent_d[i] = res0;
      end
      if (push && phase_q && (rrsp_pkg::QCntW'(i) == cnt_mid + 1'b1)) begin
        ent_d[i] = res1;
      end
    end
    cnt_d = cnt_mid + (push ? n_new : '0);
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      line_q  <= '0;
      phase_q <= 1'b0;
      blue_q  <= '0;
      cnt_q   <= '0;
    end else begin
      col_q   <= col_d;
      line_q  <= line_d;
      phase_q <= phase_d;
      blue_q  <= blue_d;
      cnt_q   <= cnt_d;
    end
  end

  // Queue payload.
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < rrsp_pkg::QDepth; i++) begin
      ent_q[i] <= ent_d[i];
    end
  end

  // Output port from the queue head.
  assign m_axis_tdata_o = {{(rrsp_pkg::OutDataW - rrsp_pkg::AddrW - rrsp_pkg::ByteW){1'b0}},
                           ent_q[0].next_read_address, ent_q[0].out_byte};
  assign m_axis_tuser_o = {ent_q[0].frame_end, ent_q[0].last_of_item};
  assign m_axis_tlast_o = ent_q[0].line_end;

  // The queue never holds more than its depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= rrsp_pkg::QCntW'(rrsp_pkg::QDepth))
    else $error("result queue overfilled");

  // The pair phase always matches the parity of the column.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == col_q[0])
    else $error("pair phase out of step with column");

  // Counters stay inside the frame.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (col_q < rrsp_pkg::ColW'(rrsp_pkg::Width)) &&
    (line_q < rrsp_pkg::LineW'(rrsp_pkg::Height)))
    else $error("scan counter out of range");

  // A pixel that closes the frame returns the scan to the first pixel.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && at_frame_end) |=> (col_q == '0) && (line_q == '0) && !phase_q)
    else $error("frame wrap missed");

  // No blue nibble is left pending at the start of a line.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && at_line_end) |=> (blue_q == '0))
    else $error("blue nibble carried across a line");

endmodule
